// File: rtl/rcst_pkg.sv
// Package for the range clear / range sum tree: widths, codes, controller types.
package rcst_pkg;

    localparam int POS_W = 10;
    localparam int CNT_W = 11;

    typedef enum logic [1:0] {
        REQ_INIT  = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_SUM   = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // frame progress
    localparam logic [1:0] PH_NEW   = 2'd0;
    localparam logic [1:0] PH_LEFT  = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;

    typedef enum logic [3:0] {
        S_RCLR,
        S_IDLE,
        S_ICLR,
        S_ENTER,
        S_LOOK,
        S_PUSH_L,
        S_PUSH_R,
        S_UNMARK,
        S_RESUME,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SWEEP,
        WR_ONE,
        WR_ZMARK,
        WR_CH_L,
        WR_CH_R,
        WR_UNMARK,
        WR_COMB
    } t_wr;

    typedef enum logic [2:0] {
        RET_KEEP,
        RET_ZERO,
        RET_ONE,
        RET_CNT,
        RET_ADD
    } t_ret;

    typedef enum logic [1:0] {
        STK_NONE,
        STK_PUSH_L,
        STK_PUSH_R,
        STK_POP
    } t_stk;

    typedef struct packed {
        logic load;
        logic rd;
        t_wr  wr;
        t_ret ret;
        t_stk stk;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic       sweep_last;
        logic       oob;
        logic       leaf;
        logic       disjoint;
        logic       full;
        logic       mark;
        logic       sp_zero;
        logic [1:0] phase;
        t_req       mode;
    } t_stat;

endpackage

// File: rtl/range_clear_sum_tree.sv
// Top level of the range clear / range sum segment tree; one request beat at a time.
// Reset: synchronous; then a clearing pass over all node memory words, busy high.
// Clear/sum: each visited node inside node memory is entered and read, then looked at; a pushed clear mark adds
// push-left, push-right and unmark steps, and each return to a parent adds a resume step.
// Init: a sweep that clears node memory, then a walk that writes each leaf and sums inner nodes.
// Result: o_done one cycle per beat, no stall; next beat accepted in the o_done cycle.
module range_clear_sum_tree #(
    parameter int LEAVES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_req_type,
    input  logic [rcst_pkg::POS_W-1:0] i_range_low,
    input  logic [rcst_pkg::POS_W-1:0] i_range_high,
    input  logic                       i_cfg_we,
    input  logic [rcst_pkg::POS_W-1:0] i_cfg_wdata,
    output logic                       o_done,
    output logic [rcst_pkg::CNT_W-1:0] o_range_sum
);
    rcst_pkg::t_cmd  cmd;
    rcst_pkg::t_stat stat;

    // controller walks the tree as an explicit stack of frames
    rcst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // node memory word is {clear mark, count}
    rcst_dp #(
        .LEAVES (LEAVES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_req_type   (i_req_type),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_range_sum  (o_range_sum)
    );

    // an accepted beat always makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accept did not raise busy");

    // the result strobe is never held high
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");

    // result strobe follows the end of a busy period
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy)) else $error("result without work");

    // a sum never exceeds 1024
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_range_sum <= rcst_pkg::CNT_W'(1024))) else $error("sum too large");

endmodule

// File: rtl/rcst_dp.sv
// Datapath: node memory, walk stack, range compare, result register.
module rcst_dp #(
    parameter int LEAVES = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rcst_pkg::t_cmd            i_cmd,
    output rcst_pkg::t_stat           o_stat,
    input  logic [1:0]                i_req_type,
    input  logic [rcst_pkg::POS_W-1:0] i_range_low,
    input  logic [rcst_pkg::POS_W-1:0] i_range_high,
    input  logic                      i_cfg_we,
    input  logic [rcst_pkg::POS_W-1:0] i_cfg_wdata,
    output logic                      o_done,
    output logic [rcst_pkg::CNT_W-1:0] o_range_sum
);
    localparam int POS_W = rcst_pkg::POS_W;
    localparam int CNT_W = rcst_pkg::CNT_W;
    localparam int NODES = 2 * LEAVES;
    localparam int NW    = $clog2(NODES);
    localparam int KW    = NW + 1;
    localparam int STK   = NW + 1;
    localparam int SPW   = $clog2(STK);
    localparam int LMAX  = (LEAVES - 1 > 1023) ? 1023 : LEAVES - 1;

    logic [CNT_W:0]     r_mem [NODES];
    logic [CNT_W:0]     r_q;
    logic [KW-1:0]      r_sk [STK];
    logic [POS_W-1:0]   r_sa [STK];
    logic [POS_W-1:0]   r_sb [STK];
    logic [1:0]         r_sph [STK];
    logic [CNT_W-1:0]   r_slv [STK];
    logic [SPW-1:0]     r_sp;
    logic [NW-1:0]      r_swp;
    logic [POS_W-1:0]   r_last;
    logic [POS_W-1:0]   r_lo;
    logic [POS_W-1:0]   r_hi;
    rcst_pkg::t_req     r_mode;
    logic [CNT_W-1:0]   r_ret;
    logic [CNT_W-1:0]   n_ret;
    logic               r_out_vld;
    logic [CNT_W-1:0]   r_out_sum;

    logic [KW-1:0]      cur_k;
    logic [POS_W-1:0]   cur_a, cur_b, mid, span;
    logic [POS_W:0]     ab_sum;
    logic [KW-1:0]      kl, kr;
    logic [SPW-1:0]     sp_up;
    logic [CNT_W-1:0]   add;
    logic               we;
    logic [KW-1:0]      waddr;
    logic [CNT_W:0]     wdata;

    assign cur_k  = r_sk[r_sp];
    assign cur_a  = r_sa[r_sp];
    assign cur_b  = r_sb[r_sp];
    assign ab_sum = {1'b0, cur_a} + {1'b0, cur_b};
    assign mid    = ab_sum[POS_W:1];
    assign kl     = {cur_k[NW-1:0], 1'b0};
    assign kr     = {cur_k[NW-1:0], 1'b1};
    assign sp_up  = r_sp + SPW'(1);
    assign add    = r_slv[r_sp] + r_ret;
    assign span   = (r_last > POS_W'(LMAX)) ? POS_W'(LMAX) : r_last;

    assign o_stat.sweep_last = (r_swp == NW'(NODES - 1));
    assign o_stat.oob        = (cur_k >= KW'(NODES));
    assign o_stat.leaf       = (cur_a == cur_b);
    assign o_stat.disjoint   = (r_lo > cur_b) || (r_hi < cur_a);
    assign o_stat.full       = (r_lo <= cur_a) && (r_hi >= cur_b);
    assign o_stat.mark       = r_q[CNT_W];
    assign o_stat.sp_zero    = (r_sp == '0);
    assign o_stat.phase      = r_sph[r_sp];
    assign o_stat.mode       = r_mode;

    // node write mux; children beyond the memory are skipped
    always_comb begin
        we    = 1'b1;
        waddr = cur_k;
        wdata = '0;
        case (i_cmd.wr)
            rcst_pkg::WR_SWEEP:  waddr = {1'b0, r_swp};
            rcst_pkg::WR_ONE:    wdata = {1'b0, CNT_W'(1)};
            rcst_pkg::WR_ZMARK:  wdata = {1'b1, CNT_W'(0)};
            rcst_pkg::WR_CH_L: begin
                waddr = kl;
                wdata = {1'b1, CNT_W'(0)};
                we    = (kl < KW'(NODES));
            end
            rcst_pkg::WR_CH_R: begin
                waddr = kr;
                wdata = {1'b1, CNT_W'(0)};
                we    = (kr < KW'(NODES));
            end
            rcst_pkg::WR_UNMARK: wdata = {1'b0, r_q[CNT_W-1:0]};
            rcst_pkg::WR_COMB:   wdata = {1'b0, add};
            default:             we    = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr[NW-1:0]] <= wdata;
        end
        if (i_cmd.rd) begin
            r_q <= r_mem[cur_k[NW-1:0]];
        end
    end

    always_comb begin
        case (i_cmd.ret)
            rcst_pkg::RET_ZERO: n_ret = '0;
            rcst_pkg::RET_ONE:  n_ret = CNT_W'(1);
            rcst_pkg::RET_CNT:  n_ret = r_q[CNT_W-1:0];
            rcst_pkg::RET_ADD:  n_ret = add;
            default:            n_ret = r_ret;
        endcase
    end

    // request latch, stack frames, return value, result
    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;
        if (i_cmd.load) begin
            r_mode   <= rcst_pkg::t_req'(i_req_type);
            r_lo     <= i_range_low;
            r_hi     <= i_range_high;
            r_sk[0]  <= KW'(1);
            r_sa[0]  <= '0;
            r_sb[0]  <= span;
            r_sph[0] <= rcst_pkg::PH_NEW;
        end
        case (i_cmd.stk)
            rcst_pkg::STK_PUSH_L: begin
                r_sph[r_sp]  <= rcst_pkg::PH_LEFT;
                r_sk[sp_up]  <= kl;
                r_sa[sp_up]  <= cur_a;
                r_sb[sp_up]  <= mid;
                r_sph[sp_up] <= rcst_pkg::PH_NEW;
            end
            rcst_pkg::STK_PUSH_R: begin
                r_sph[r_sp]  <= rcst_pkg::PH_RIGHT;
                r_slv[r_sp]  <= r_ret;
                r_sk[sp_up]  <= kr;
                r_sa[sp_up]  <= mid + POS_W'(1);
                r_sb[sp_up]  <= cur_b;
                r_sph[sp_up] <= rcst_pkg::PH_NEW;
            end
            default: ;
        endcase
        if (i_cmd.out_ld) begin
            r_out_sum <= (r_mode == rcst_pkg::REQ_SUM) ? r_ret : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_swp     <= '0;
            r_last    <= POS_W'(1023);
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.out_ld;
            if (i_cfg_we) begin
                r_last <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_swp <= '0;
            end else if (i_cmd.wr == rcst_pkg::WR_SWEEP) begin
                r_swp <= r_swp + NW'(1);
            end
            if (i_cmd.load) begin
                r_sp <= '0;
            end else begin
                case (i_cmd.stk)
                    rcst_pkg::STK_PUSH_L, rcst_pkg::STK_PUSH_R: r_sp <= sp_up;
                    // root pop leaves the pointer on frame 0
                    rcst_pkg::STK_POP: begin
                        if (r_sp != '0) r_sp <= r_sp - SPW'(1);
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_done      = r_out_vld;
    assign o_range_sum = r_out_sum;

endmodule

// File: rtl/rcst_ctrl.sv
// Controller: sequences sweeps and the node-by-node tree walk.
module rcst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [1:0]      i_req_type,
    input  rcst_pkg::t_stat i_stat,
    output rcst_pkg::t_cmd  o_cmd,
    output logic            busy
);
    rcst_pkg::t_state r_state, n_state;
    rcst_pkg::t_state pop_state;

    assign pop_state = i_stat.sp_zero ? rcst_pkg::S_DONE : rcst_pkg::S_RESUME;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcst_pkg::S_RCLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '{load: 1'b0, rd: 1'b0, wr: rcst_pkg::WR_NONE, ret: rcst_pkg::RET_KEEP,
                    stk: rcst_pkg::STK_NONE, out_ld: 1'b0};
        case (r_state)
            rcst_pkg::S_RCLR: begin
                o_cmd.wr = rcst_pkg::WR_SWEEP;
                if (i_stat.sweep_last) n_state = rcst_pkg::S_IDLE;
            end
            rcst_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (rcst_pkg::t_req'(i_req_type))
                        rcst_pkg::REQ_INIT:  n_state = rcst_pkg::S_ICLR;
                        rcst_pkg::REQ_CLEAR: n_state = rcst_pkg::S_ENTER;
                        rcst_pkg::REQ_SUM:   n_state = rcst_pkg::S_ENTER;
                        default:             n_state = rcst_pkg::S_DONE;
                    endcase
                end
            end
            rcst_pkg::S_ICLR: begin
                o_cmd.wr = rcst_pkg::WR_SWEEP;
                if (i_stat.sweep_last) n_state = rcst_pkg::S_ENTER;
            end
            rcst_pkg::S_ENTER: begin
                if (i_stat.oob) begin
                    o_cmd.ret = rcst_pkg::RET_ZERO;
                    o_cmd.stk = rcst_pkg::STK_POP;
                    n_state   = pop_state;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = rcst_pkg::S_LOOK;
                end
            end
            rcst_pkg::S_LOOK: begin
                case (i_stat.mode)
                    rcst_pkg::REQ_INIT: begin
                        if (i_stat.leaf) begin
                            o_cmd.wr  = rcst_pkg::WR_ONE;
                            o_cmd.ret = rcst_pkg::RET_ONE;
                            o_cmd.stk = rcst_pkg::STK_POP;
                            n_state   = pop_state;
                        end else begin
                            o_cmd.stk = rcst_pkg::STK_PUSH_L;
                            n_state   = rcst_pkg::S_ENTER;
                        end
                    end
                    rcst_pkg::REQ_CLEAR, rcst_pkg::REQ_SUM: begin
                        if (i_stat.disjoint) begin
                            o_cmd.ret = (i_stat.mode == rcst_pkg::REQ_SUM) ?
                                        rcst_pkg::RET_ZERO : rcst_pkg::RET_CNT;
                            o_cmd.stk = rcst_pkg::STK_POP;
                            n_state   = pop_state;
                        end else if (i_stat.full) begin
                            if (i_stat.mode == rcst_pkg::REQ_SUM) begin
                                o_cmd.ret = rcst_pkg::RET_CNT;
                            end else begin
                                o_cmd.wr  = rcst_pkg::WR_ZMARK;
                                o_cmd.ret = rcst_pkg::RET_ZERO;
                            end
                            o_cmd.stk = rcst_pkg::STK_POP;
                            n_state   = pop_state;
                        end else if (i_stat.mark) begin
                            n_state = rcst_pkg::S_PUSH_L;
                        end else begin
                            o_cmd.stk = rcst_pkg::STK_PUSH_L;
                            n_state   = rcst_pkg::S_ENTER;
                        end
                    end
                    default: begin
                        o_cmd.stk = rcst_pkg::STK_POP;
                        n_state   = pop_state;
                    end
                endcase
            end
            // lazy mark moves to both children, then the node drops its own
            rcst_pkg::S_PUSH_L: begin
                o_cmd.wr = rcst_pkg::WR_CH_L;
                n_state  = rcst_pkg::S_PUSH_R;
            end
            rcst_pkg::S_PUSH_R: begin
                o_cmd.wr = rcst_pkg::WR_CH_R;
                n_state  = rcst_pkg::S_UNMARK;
            end
            rcst_pkg::S_UNMARK: begin
                o_cmd.wr  = rcst_pkg::WR_UNMARK;
                o_cmd.stk = rcst_pkg::STK_PUSH_L;
                n_state   = rcst_pkg::S_ENTER;
            end
            rcst_pkg::S_RESUME: begin
                if (i_stat.phase == rcst_pkg::PH_LEFT) begin
                    o_cmd.stk = rcst_pkg::STK_PUSH_R;
                    n_state   = rcst_pkg::S_ENTER;
                end else begin
                    o_cmd.ret = rcst_pkg::RET_ADD;
                    if (i_stat.mode != rcst_pkg::REQ_SUM) o_cmd.wr = rcst_pkg::WR_COMB;
                    o_cmd.stk = rcst_pkg::STK_POP;
                    n_state   = pop_state;
                end
            end
            rcst_pkg::S_DONE: begin
                o_cmd.out_ld = 1'b1;
                n_state      = rcst_pkg::S_IDLE;
            end
            default: n_state = rcst_pkg::S_IDLE;
        endcase
    end

    assign busy = (r_state != rcst_pkg::S_IDLE);

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the range clear / range sum segment tree.
`timescale 1ns / 1ps

module testbench;

    localparam int LEAVES    = 1024;
    localparam int NODES     = 2 * LEAVES;
    localparam int WDOG_MAX  = 40000;   // watchdog limit, above the quiet stretch of an init
    localparam int MAX_SHOWN = 10;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the tree and the expected sums.
    // ------------------------------------------------------------------
    class sum_scoreboard;
        logic [rcst_pkg::CNT_W-1:0] cnt[NODES];
        bit                         lazy_clr[NODES];
        logic [rcst_pkg::POS_W-1:0] top_pos;
        logic [rcst_pkg::CNT_W-1:0] pending_sums[$];
        int                         n_bad;

        function new();
            foreach (cnt[k]) begin
                cnt[k] = '0;
                lazy_clr[k] = 1'b0;
            end
            top_pos = 10'd1023;
            n_bad = 0;
        endfunction

        function logic [rcst_pkg::CNT_W-1:0] cnt_of(int k);
            return (k < NODES) ? cnt[k] : '0;
        endfunction

        function void zero_mark(int k);
            if (k < NODES) begin
                cnt[k] = '0;
                lazy_clr[k] = 1'b1;
            end
        endfunction

        // hand a pending clear down to both children
        function void pass_mark_down(int k);
            if (k < NODES && lazy_clr[k]) begin
                zero_mark(2 * k);
                zero_mark(2 * k + 1);
                lazy_clr[k] = 1'b0;
            end
        endfunction

        function void build(int k, int a, int b);
            int m;
            if (k >= NODES) return;
            if (a == b) begin
                cnt[k] = rcst_pkg::CNT_W'(1);
                return;
            end
            m = (a + b) / 2;
            build(2 * k, a, m);
            build(2 * k + 1, m + 1, b);
            cnt[k] = cnt_of(2 * k) + cnt_of(2 * k + 1);
        endfunction

        function void clear_span(int k, int a, int b, int lo, int hi);
            int m;
            if (k >= NODES || lo > b || hi < a) return;
            if (lo <= a && hi >= b) begin
                zero_mark(k);
                return;
            end
            m = (a + b) / 2;
            pass_mark_down(k);
            clear_span(2 * k, a, m, lo, hi);
            clear_span(2 * k + 1, m + 1, b, lo, hi);
            cnt[k] = cnt_of(2 * k) + cnt_of(2 * k + 1);
        endfunction

        function int sum_span(int k, int a, int b, int lo, int hi);
            int m;
            if (k >= NODES || lo > b || hi < a) return 0;
            if (lo <= a && hi >= b) return int'(cnt[k]);
            pass_mark_down(k);
            m = (a + b) / 2;
            return sum_span(2 * k, a, m, lo, hi) + sum_span(2 * k + 1, m + 1, b, lo, hi);
        endfunction

        // note one accepted request beat
        function void note_request(rcst_pkg::t_req kind, int lo, int hi);
            int top;
            int total;
            top = (int'(top_pos) > LEAVES - 1) ? LEAVES - 1 : int'(top_pos);
            total = 0;
            case (kind)
                rcst_pkg::REQ_INIT: begin
                    foreach (cnt[k]) begin
                        cnt[k] = '0;
                        lazy_clr[k] = 1'b0;
                    end
                    build(1, 0, top);
                end
                rcst_pkg::REQ_CLEAR: clear_span(1, 0, top, lo, hi);
                rcst_pkg::REQ_SUM:   total = sum_span(1, 0, top, lo, hi);
                default:             total = 0;
            endcase
            pending_sums.push_back(rcst_pkg::CNT_W'(total));
        endfunction

        // compare one result beat with the oldest expected sum
        function void check_sum(logic [rcst_pkg::CNT_W-1:0] got);
            logic [rcst_pkg::CNT_W-1:0] want;
            if (pending_sums.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_SHOWN)
                    $display("ERROR: unexpected result beat, range_sum=%0d", got);
                return;
            end
            want = pending_sums.pop_front();
            if (got !== want) begin
                n_bad++;
                if (n_bad <= MAX_SHOWN)
                    $display("ERROR: range_sum expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [1:0]                 i_req_type;
    logic [rcst_pkg::POS_W-1:0] i_range_low;
    logic [rcst_pkg::POS_W-1:0] i_range_high;
    logic                       i_cfg_we;
    logic [rcst_pkg::POS_W-1:0] i_cfg_wdata;
    logic                       o_done;
    logic [rcst_pkg::CNT_W-1:0] o_range_sum;

    sum_scoreboard sb;
    int            quiet_cycles;
    bit            allow_gaps;

    range_clear_sum_tree #(.LEAVES(LEAVES)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_range_low (i_range_low),
        .i_range_high(i_range_high),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_range_sum (o_range_sum)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Monitor: request beats feed the model, done beats are checked.
    // Both sampled at the rising edge; the watchdog counts quiet cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_request(rcst_pkg::t_req'(i_req_type), int'(i_range_low),
                                int'(i_range_high));
            if (o_done)
                sb.check_sum(o_range_sum);
            if ((start && !busy) || o_done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: nothing accepted and no result for too long means a hang.
    initial begin
        quiet_cycles = 0;
        wait (quiet_cycles >= WDOG_MAX);
        $display("testbench NOT OK");
        $finish;
    end

    // Send one request beat; inputs move at the falling edge only.
    // start stays high after the accept (block is busy); drain or a gap drops it.
    task automatic send_req(rcst_pkg::t_req kind, int lo, int hi);
        int gap;
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= kind;
        i_range_low  <= rcst_pkg::POS_W'(lo);
        i_range_high <= rcst_pkg::POS_W'(hi);
        // wait for the accepting edge
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Drain all results, then let the block settle before touching config.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_sums.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_top(int value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rcst_pkg::POS_W'(value);
        sb.top_pos   = rcst_pkg::POS_W'(value);   // takes effect at the next edge
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random request biased toward clears and sums inside the covered span.
    task automatic random_req(int top);
        int pick;
        int lo;
        int hi;
        int tmp;
        rcst_pkg::t_req kind;
        pick = int'($urandom_range(0, 99));
        if (pick < 3)       kind = rcst_pkg::REQ_INIT;
        else if (pick < 40) kind = rcst_pkg::REQ_CLEAR;
        else if (pick < 96) kind = rcst_pkg::REQ_SUM;
        else                kind = rcst_pkg::REQ_NONE;
        if ($urandom_range(0, 9) == 0) begin
            // full-width noise: empty and out-of-span ranges
            lo = int'($urandom_range(0, 1023));
            hi = int'($urandom_range(0, 1023));
        end else begin
            lo = int'($urandom_range(0, top));
            hi = int'($urandom_range(0, top));
            if (lo > hi) begin
                tmp = lo; lo = hi; hi = tmp;
            end
            // clears mostly narrow so sums still see ones
            if (kind == rcst_pkg::REQ_CLEAR && $urandom_range(0, 3) != 0) begin
                tmp = lo + int'($urandom_range(0, 7));
                hi = (tmp > top) ? top : tmp;
            end
        end
        send_req(kind, lo, hi);
    endtask

    initial begin
        int tops[5];
        sb = new();
        tops = '{1023, 0, 1, 37, 512};
        allow_gaps   = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req_type   = rcst_pkg::REQ_NONE;
        i_range_low  = '0;
        i_range_high = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a sum and a clear before any init, unknown type, init, extremes, empty range.
        send_req(rcst_pkg::REQ_SUM, 0, 1023);
        send_req(rcst_pkg::REQ_CLEAR, 0, 1023);
        send_req(rcst_pkg::REQ_NONE, 1023, 0);
        send_req(rcst_pkg::REQ_INIT, 0, 0);
        send_req(rcst_pkg::REQ_SUM, 0, 1023);
        send_req(rcst_pkg::REQ_SUM, 1023, 1023);
        send_req(rcst_pkg::REQ_SUM, 600, 5);            // empty range
        send_req(rcst_pkg::REQ_CLEAR, 600, 5);
        send_req(rcst_pkg::REQ_CLEAR, 0, 0);
        send_req(rcst_pkg::REQ_CLEAR, 1023, 1023);
        send_req(rcst_pkg::REQ_CLEAR, 100, 300);
        send_req(rcst_pkg::REQ_SUM, 0, 511);
        send_req(rcst_pkg::REQ_SUM, 512, 1023);
        send_req(rcst_pkg::REQ_SUM, 250, 700);
        send_req(rcst_pkg::REQ_NONE, 341, 682);
        send_req(rcst_pkg::REQ_SUM, 341, 682);

        // Shrink the span without rebuilding: stale counts walked in a new shape.
        write_top(5);
        send_req(rcst_pkg::REQ_SUM, 0, 1023);
        send_req(rcst_pkg::REQ_CLEAR, 2, 3);
        send_req(rcst_pkg::REQ_SUM, 0, 5);
        send_req(rcst_pkg::REQ_INIT, 0, 0);
        send_req(rcst_pkg::REQ_SUM, 3, 1023);

        // Random phases over several spans, extremes included.
        allow_gaps = 1'b1;
        foreach (tops[t]) begin
            write_top(tops[t]);
            send_req(rcst_pkg::REQ_INIT, int'($urandom_range(0, 1023)),
                     int'($urandom_range(0, 1023)));
            for (int n = 0; n < 140; n++) begin
                if (t == 4 && n == 100)
                    allow_gaps = 1'b0;      // closing stretch runs without gaps
                if (n == 70)
                    drain();                // sender holds off until all results are in
                random_req(tops[t]);
            end
        end

        drain();
        repeat (50) @(negedge i_clk);
        if (sb.n_bad == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
